/* design/rbfai_pkg.sv */
// Package: shared types, constants and fixed-point helpers of the adaptive impedance step
`timescale 1ns / 1ps

package rbfai_pkg;

    localparam int DATA_WIDTH      = 32;
    localparam int FRAC_BITS       = 16;
    localparam int NUM_CENTERS_DEF = 6;
    localparam int IN_WIDTH        = 32;
    localparam int CFG_DATA_W      = 31;
    localparam int CFG_IDX_W       = 8;
    localparam int WIDE_W          = 64;

    localparam logic signed [WIDE_W-1:0] WIDE_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic [WIDE_W-1:0]        LN2_Q30  = 64'd744261118;
    localparam logic [30:0]              ONE_Q30  = 31'h4000_0000;

    // reciprocals: ln2 split exact for 35-bit dividends, Horner divides for 30-bit ones
    localparam int                LN2_RCP_SH    = 65;
    localparam int                HORNER_RCP_SH = 34;
    localparam logic [WIDE_W-1:0] LN2_RCP = 64'((((128'd1 << LN2_RCP_SH)
                                                  + 128'(LN2_Q30)) - 128'd1) / 128'(LN2_Q30));

    localparam logic [CFG_DATA_W-1:0] MASS_RST   = 31'd65536;
    localparam logic [CFG_DATA_W-1:0] BASE_RST   = 31'd39321600;
    localparam logic [CFG_DATA_W-1:0] GAIN_RST   = 31'd65536000;
    localparam logic [CFG_DATA_W-1:0] SPREAD_RST = 31'd436906667;

    // divider pass length and top Horner divisor
    localparam logic [6:0] DIV_FULL   = 7'd64;
    localparam logic [3:0] HORNER_TOP = 4'd10;

    typedef logic signed [WIDE_W-1:0]     t_wide;
    typedef logic signed [DATA_WIDTH-1:0] t_data;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASS   = 8'd0,
        CFG_BASE   = 8'd1,
        CFG_GAIN   = 8'd2,
        CFG_SPREAD = 8'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [IN_WIDTH-1:0] force_error;
    } t_in_item;

    typedef struct packed {
        t_data offset_step;
        t_data damping_out;
        t_data offset_total;
        logic  divide_fault;
    } t_out_item;

    function automatic logic [WIDE_W-1:0] mag64(input t_wide v);
        return v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
    endfunction

    function automatic t_wide signed_of(input logic [WIDE_W-1:0] m, input logic neg);
        logic [WIDE_W-1:0] c;
        c = (m > WIDE_W'(WIDE_MAX)) ? WIDE_W'(WIDE_MAX) : m;
        return neg ? -t_wide'(c) : t_wide'(c);
    endfunction

    function automatic t_wide sat_wide(input t_wide v);
        if (v > WIDE_MAX) return WIDE_MAX;
        if (v < -WIDE_MAX) return -WIDE_MAX;
        return v;
    endfunction

    function automatic t_wide sat_dw(input t_wide v);
        t_wide lim;
        lim = t_wide'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);
        if (v > lim) return lim;
        if (v < -lim - 64'sd1) return -lim - 64'sd1;
        return v;
    endfunction

    // ceil(2^34 / k) for the Horner step divisors
    function automatic logic [WIDE_W-1:0] horner_rcp(input logic [3:0] k);
        case (k)
            4'd1:    return (64'd1 << HORNER_RCP_SH);
            4'd2:    return ((64'd1 << HORNER_RCP_SH) + 64'd1) / 64'd2;
            4'd3:    return ((64'd1 << HORNER_RCP_SH) + 64'd2) / 64'd3;
            4'd4:    return ((64'd1 << HORNER_RCP_SH) + 64'd3) / 64'd4;
            4'd5:    return ((64'd1 << HORNER_RCP_SH) + 64'd4) / 64'd5;
            4'd6:    return ((64'd1 << HORNER_RCP_SH) + 64'd5) / 64'd6;
            4'd7:    return ((64'd1 << HORNER_RCP_SH) + 64'd6) / 64'd7;
            4'd8:    return ((64'd1 << HORNER_RCP_SH) + 64'd7) / 64'd8;
            4'd9:    return ((64'd1 << HORNER_RCP_SH) + 64'd8) / 64'd9;
            4'd10:   return ((64'd1 << HORNER_RCP_SH) + 64'd9) / 64'd10;
            default: return '0;
        endcase
    endfunction

endpackage

/* design/rbfai_stream_if.sv */
// Interface: valid/ready stream channel carrying one payload item per transaction
`timescale 1ns / 1ps

interface rbfai_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/rbf_adaptive_impedance_step_top.sv */
// Top level: RBF-network adaptive impedance step on a shared multiplier and divider
`timescale 1ns / 1ps

// Channel   Dir  Payload                                          Handshake
// i_in      in   force_error (s32 Q16.16)                         valid/ready
// o_out     out  offset_step, damping_out, offset_total (s32),    valid/ready
//                divide_fault (1 bit)
// i_cfg_*   in   register index (8 bit), data (31 bit)            write enable only
//
// A sample waits in the final state while o_out.ready is low and the output register full.
// Work runs on the one-bit-per-cycle divider (64 quotient bits per Gaussian quotient and
// filter divide) and a 64x64 multiply of four 32x32 partial products; ln2 split and
// Horner divides go by reciprocal multiply. Reset loads the default configuration.
// i_in.ready is high only while the sequencer is idle. A finished result sits in the
// output register, so a new transaction can start while it waits for o_out.ready.
// Synchronous active-low reset clears sequencer, histories, weights and output valid.
module rbf_adaptive_impedance_step_top #(
    parameter int NUM_CENTERS = rbfai_pkg::NUM_CENTERS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rbfai_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rbfai_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rbfai_stream_if.sink                     i_in,
    rbfai_stream_if.source                   o_out
);
    import rbfai_pkg::*;

    localparam int IDX_W = (NUM_CENTERS > 1) ? $clog2(NUM_CENTERS) : 1;

    typedef enum logic [24:0] {
        S_IDLE = 25'h0000001,
        S_MUL  = 25'h0000002,
        S_MRND = 25'h0000004,
        S_DIV  = 25'h0000008,
        S_T1   = 25'h0000010,
        S_T2   = 25'h0000020,
        S_G0   = 25'h0000040,
        S_G1   = 25'h0000080,
        S_G2   = 25'h0000100,
        S_G3   = 25'h0000200,
        S_H0   = 25'h0000400,
        S_H1   = 25'h0000800,
        S_H2   = 25'h0001000,
        S_G4   = 25'h0002000,
        S_W0   = 25'h0004000,
        S_W1   = 25'h0008000,
        S_W2   = 25'h0010000,
        S_B0   = 25'h0020000,
        S_B1   = 25'h0040000,
        S_B2   = 25'h0080000,
        S_F1   = 25'h0100000,
        S_F2   = 25'h0200000,
        S_F3   = 25'h0400000,
        S_F4   = 25'h0800000,
        S_FIN  = 25'h1000000
    } t_state;

    // centre table, worked out at elaboration
    t_data w_centre [NUM_CENTERS];
    for (genvar g = 0; g < NUM_CENTERS; g++) begin : g_centre
        localparam longint CNum = longint'(2 * g - (NUM_CENTERS - 1)) * (longint'(1) << FRAC_BITS);
        localparam longint CAbs = (CNum < 0) ? -CNum : CNum;
        localparam longint CMag = (CAbs + (NUM_CENTERS - 1) / 2) / (NUM_CENTERS - 1);
        assign w_centre[g] = DATA_WIDTH'((CNum < 0) ? -CMag : CMag);
    end

    // configuration
    logic [CFG_DATA_W-1:0] r_mass, r_base, r_gain, r_spread;

    // sequencer and working values
    t_state              r_state, n_state, r_ret, n_ret;
    t_data               r_fe, n_fe;
    t_wide               r_t, n_t, r_acc, n_acc, r_k, n_k;
    t_wide               r_w1, n_w1, r_w3, n_w3, r_num, n_num;
    t_data               r_b, n_b, r_y, n_y;
    logic                r_fault, n_fault;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [FRAC_BITS:0]  r_h, n_h;
    logic [5:0]          r_n, n_n;
    logic [29:0]         r_r, n_r;
    logic [30:0]         r_p, n_p;
    logic [3:0]          r_kk, n_kk;

    // model state
    t_data r_ih1, n_ih1, r_ih2, n_ih2, r_oh1, n_oh1, r_oh2, n_oh2, r_accum, n_accum;
    t_data r_w [NUM_CENTERS];
    t_data n_w [NUM_CENTERS];

    // shared multiplier
    logic [WIDE_W-1:0]   r_ma, n_ma, r_mb, n_mb;
    logic                r_mneg, n_mneg;
    logic [2*WIDE_W-1:0] r_prod, n_prod;
    logic [1:0]          r_mcnt, n_mcnt;
    t_wide               r_qres, n_qres;

    // shared divider
    logic [WIDE_W-1:0]   r_rem, n_rem, r_dsh, n_dsh, r_dd, n_dd, r_quo, n_quo;
    logic [6:0]          r_dcnt, n_dcnt;
    logic                r_dneg, n_dneg;

    // output register
    logic                r_ovalid, n_ovalid;
    t_out_item           r_odata, n_odata;

    // unit requests from the sequencer
    logic                mul_go, div_go;
    t_wide               mul_a, mul_b;
    logic [WIDE_W-1:0]   div_rem0, div_dsh0, div_dd0;
    logic [6:0]          div_cnt0;
    t_state              go_ret;

    // datapath helpers
    logic [31:0]         pp_a, pp_b;
    logic [WIDE_W-1:0]   pp;
    logic [1:0]          pp_off;
    logic [2*WIDE_W-1:0] pp_sh, rnd;
    logic [WIDE_W-1:0]   rnd_lo;
    logic [WIDE_W:0]     div_sh;
    t_wide               d_c, wsum, b_w, m_w, num0, w2_w;
    logic [WIDE_W-1:0]   ad, un, ud, hv, r30_w;
    logic [2*WIDE_W-1:0] qn;
    logic [6:0]          sh;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

    // 32x32 partial product, one quarter a cycle
    always_comb begin
        pp_a   = r_mcnt[1] ? r_ma[63:32] : r_ma[31:0];
        pp_b   = r_mcnt[0] ? r_mb[63:32] : r_mb[31:0];
        pp     = pp_a * pp_b;
        pp_off = {1'b0, r_mcnt[1]} + {1'b0, r_mcnt[0]};
        case (pp_off)
            2'd0:    pp_sh = {64'd0, pp};
            2'd1:    pp_sh = {32'd0, pp, 32'd0};
            default: pp_sh = {pp, 64'd0};
        endcase
        // Q rounding: nearest, ties away from zero on the magnitude
        rnd    = r_prod + ((2*WIDE_W)'(1) << (FRAC_BITS - 1));
        rnd_lo = (rnd[2*WIDE_W-1:FRAC_BITS+WIDE_W] != '0) ? WIDE_W'(WIDE_MAX)
                                                          : rnd[FRAC_BITS+WIDE_W-1:FRAC_BITS];
        div_sh = {r_rem, r_dsh[WIDE_W-1]};
    end

    always_comb begin
        n_state = r_state;  n_ret = r_ret;
        n_fe = r_fe;  n_t = r_t;  n_acc = r_acc;  n_k = r_k;
        n_w1 = r_w1;  n_w3 = r_w3;  n_num = r_num;  n_b = r_b;  n_y = r_y;
        n_fault = r_fault;  n_idx = r_idx;  n_h = r_h;  n_n = r_n;  n_r = r_r;
        n_p = r_p;  n_kk = r_kk;
        n_ih1 = r_ih1;  n_ih2 = r_ih2;  n_oh1 = r_oh1;  n_oh2 = r_oh2;
        n_accum = r_accum;
        n_w = r_w;
        n_ma = r_ma;  n_mb = r_mb;  n_mneg = r_mneg;  n_prod = r_prod;
        n_mcnt = r_mcnt;  n_qres = r_qres;
        n_rem = r_rem;  n_dsh = r_dsh;  n_dd = r_dd;  n_quo = r_quo;
        n_dcnt = r_dcnt;  n_dneg = r_dneg;
        n_ovalid = r_ovalid & ~o_out.ready;
        n_odata = r_odata;
        mul_go = 1'b0;  mul_a = '0;  mul_b = '0;
        div_go = 1'b0;  div_rem0 = '0;  div_dsh0 = '0;  div_dd0 = '0;  div_cnt0 = '0;
        go_ret = S_IDLE;
        d_c = '0;  wsum = '0;  b_w = '0;  m_w = '0;  num0 = '0;  w2_w = '0;
        ad = '0;  un = '0;  ud = '0;  hv = '0;  r30_w = '0;  qn = '0;  sh = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_fe   = DATA_WIDTH'(sat_dw(WIDE_W'(i_in.data.force_error)));
                    mul_go = 1'b1;
                    mul_a  = t_wide'(WIDE_W'(r_gain));
                    mul_b  = sat_dw(WIDE_W'(i_in.data.force_error));
                    go_ret = S_T1;
                end
            end
            S_MUL: begin
                n_prod = r_prod + pp_sh;
                n_mcnt = r_mcnt + 2'd1;
                if (r_mcnt == 2'd3) begin
                    n_state = S_MRND;
                end
            end
            S_MRND: begin
                n_qres  = signed_of(rnd_lo, r_mneg);
                n_state = r_ret;
            end
            S_DIV: begin
                if (div_sh >= {1'b0, r_dd}) begin
                    n_rem = WIDE_W'(div_sh - {1'b0, r_dd});
                    n_quo = {r_quo[WIDE_W-2:0], 1'b1};
                end else begin
                    n_rem = div_sh[WIDE_W-1:0];
                    n_quo = {r_quo[WIDE_W-2:0], 1'b0};
                end
                n_dsh  = {r_dsh[WIDE_W-2:0], 1'b0};
                n_dcnt = r_dcnt - 7'd1;
                if (r_dcnt == 7'd1) begin
                    n_state = r_ret;
                end
            end
            S_T1: begin
                mul_go = 1'b1;
                mul_a  = r_qres;
                mul_b  = WIDE_W'(r_oh1) - WIDE_W'(r_oh2);
                go_ret = S_T2;
            end
            S_T2: begin
                n_t     = r_qres;
                n_idx   = '0;
                n_acc   = '0;
                n_state = S_G0;
            end
            S_G0: begin
                d_c = WIDE_W'(r_fe) - WIDE_W'(w_centre[r_idx]);
                ad  = mag64(d_c);
                if (ad >= 64'h8000_0000) begin
                    n_h     = '0;
                    n_state = S_W0;
                end else begin
                    mul_go = 1'b1;
                    mul_a  = t_wide'(ad);
                    mul_b  = t_wide'(ad);
                    go_ret = S_G1;
                end
            end
            S_G1: begin
                div_go   = 1'b1;
                div_dsh0 = r_prod[WIDE_W-1:0];
                div_dd0  = (r_spread == '0) ? 64'd1 : WIDE_W'(r_spread);
                div_cnt0 = DIV_FULL;
                go_ret   = S_G2;
            end
            S_G2: begin
                if (r_quo >= (64'd24 << FRAC_BITS)) begin
                    n_h     = '0;
                    n_state = S_W0;
                end else begin
                    // n = floor(x / ln2) in Q30 by reciprocal multiply
                    mul_go = 1'b1;
                    mul_a  = t_wide'(r_quo << (30 - FRAC_BITS));
                    mul_b  = t_wide'(LN2_RCP);
                    go_ret = S_G3;
                end
            end
            S_G3: begin
                r30_w   = r_quo << (30 - FRAC_BITS);
                r30_w   = r30_w - WIDE_W'(r_prod[LN2_RCP_SH +: 6]) * LN2_Q30;
                n_n     = r_prod[LN2_RCP_SH +: 6];
                n_r     = r30_w[29:0];
                n_p     = ONE_Q30;
                n_kk    = HORNER_TOP;
                n_state = S_H0;
            end
            S_H0: begin
                mul_go = 1'b1;
                mul_a  = t_wide'(WIDE_W'(r_r));
                mul_b  = t_wide'(WIDE_W'(r_p));
                go_ret = S_H1;
            end
            S_H1: begin
                // divide by k through its reciprocal
                mul_go = 1'b1;
                mul_a  = t_wide'(WIDE_W'(r_prod[59:30]));
                mul_b  = t_wide'(horner_rcp(r_kk));
                go_ret = S_H2;
            end
            S_H2: begin
                n_p  = ONE_Q30 - {1'b0, r_prod[HORNER_RCP_SH +: 30]};
                n_kk = r_kk - 4'd1;
                n_state = (r_kk == 4'd1) ? S_G4 : S_H0;
            end
            S_G4: begin
                sh      = 7'(30 - FRAC_BITS) + 7'(r_n);
                hv      = (WIDE_W'(r_p) + (64'd1 << (sh - 7'd1))) >> sh;
                n_h     = hv[FRAC_BITS:0];
                n_state = S_W0;
            end
            S_W0: begin
                mul_go = 1'b1;
                mul_a  = r_t;
                mul_b  = t_wide'(WIDE_W'(r_h));
                go_ret = S_W1;
            end
            S_W1: begin
                wsum         = WIDE_W'(r_w[r_idx]) + r_qres;
                n_w[r_idx]   = DATA_WIDTH'(sat_dw(wsum));
                mul_go       = 1'b1;
                mul_a        = sat_dw(wsum);
                mul_b        = t_wide'(WIDE_W'(r_h));
                go_ret       = S_W2;
            end
            S_W2: begin
                n_acc = sat_wide(r_acc + r_qres);
                if (r_idx == IDX_W'(NUM_CENTERS - 1)) begin
                    n_state = S_B0;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_G0;
                end
            end
            S_B0: begin
                b_w    = sat_dw(sat_wide(t_wide'(WIDE_W'(r_base)) + r_acc));
                n_b    = DATA_WIDTH'(b_w);
                mul_go = 1'b1;
                mul_a  = b_w;
                mul_b  = b_w;
                go_ret = S_B1;
            end
            S_B1: begin
                n_k     = r_qres >>> 2;
                n_state = S_B2;
            end
            S_B2: begin
                // bilinear coefficients scaled by 1/T^2
                m_w   = t_wide'(WIDE_W'(r_mass));
                b_w   = WIDE_W'(r_b);
                n_w1  = sat_wide(sat_wide(m_w * 64'sd10000 + b_w * 64'sd100) + r_k);
                w2_w  = sat_wide(-(m_w * 64'sd20000) + (r_k <<< 1));
                n_w3  = sat_wide(sat_wide(m_w * 64'sd10000 - b_w * 64'sd100) + r_k);
                num0  = WIDE_W'(r_fe) + (WIDE_W'(r_ih1) <<< 1) + WIDE_W'(r_ih2);
                n_num = num0;
                mul_go = 1'b1;
                mul_a  = w2_w;
                mul_b  = WIDE_W'(r_oh1);
                go_ret = S_F1;
            end
            S_F1: begin
                n_num  = sat_wide(r_num - r_qres);
                mul_go = 1'b1;
                mul_a  = r_w3;
                mul_b  = WIDE_W'(r_oh2);
                go_ret = S_F2;
            end
            S_F2: begin
                n_num   = sat_wide(r_num - r_qres);
                n_state = S_F3;
            end
            S_F3: begin
                if (r_w1 == '0) begin
                    n_fault = 1'b1;
                    n_y = (r_num > 0) ? DATA_WIDTH'(sat_dw(WIDE_MAX))
                        : (r_num < 0) ? DATA_WIDTH'(sat_dw(-WIDE_MAX)) : '0;
                    n_state = S_FIN;
                end else begin
                    n_fault = 1'b0;
                    un = mag64(r_num);
                    ud = mag64(r_w1);
                    qn = ((2*WIDE_W)'(un) << FRAC_BITS) + (2*WIDE_W)'(ud >> 1);
                    n_dneg = r_num[WIDE_W-1] ^ r_w1[WIDE_W-1];
                    if (qn[2*WIDE_W-1:WIDE_W] >= ud) begin
                        n_y = DATA_WIDTH'(sat_dw(signed_of(WIDE_W'(WIDE_MAX),
                                          r_num[WIDE_W-1] ^ r_w1[WIDE_W-1])));
                        n_state = S_FIN;
                    end else begin
                        div_go   = 1'b1;
                        div_rem0 = qn[2*WIDE_W-1:WIDE_W];
                        div_dsh0 = qn[WIDE_W-1:0];
                        div_dd0  = ud;
                        div_cnt0 = DIV_FULL;
                        go_ret   = S_F4;
                    end
                end
            end
            S_F4: begin
                n_y     = DATA_WIDTH'(sat_dw(signed_of(r_quo, r_dneg)));
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_ovalid || o_out.ready) begin
                    n_oh2   = r_oh1;
                    n_oh1   = r_y;
                    n_ih2   = r_ih1;
                    n_ih1   = r_fe;
                    n_accum = DATA_WIDTH'(sat_dw(WIDE_W'(r_accum) + WIDE_W'(r_y)));
                    n_odata.offset_step  = r_y;
                    n_odata.damping_out  = r_b;
                    n_odata.offset_total = DATA_WIDTH'(sat_dw(WIDE_W'(r_accum) + WIDE_W'(r_y)));
                    n_odata.divide_fault = r_fault;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (mul_go) begin
            n_ma    = mag64(mul_a);
            n_mb    = mag64(mul_b);
            n_mneg  = mul_a[WIDE_W-1] ^ mul_b[WIDE_W-1];
            n_prod  = '0;
            n_mcnt  = '0;
            n_ret   = go_ret;
            n_state = S_MUL;
        end
        if (div_go) begin
            n_rem   = div_rem0;
            n_dsh   = div_dsh0;
            n_dd    = div_dd0;
            n_quo   = '0;
            n_dcnt  = div_cnt0;
            n_ret   = go_ret;
            n_state = S_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_ovalid <= 1'b0;
            r_ih1    <= '0;
            r_ih2    <= '0;
            r_oh1    <= '0;
            r_oh2    <= '0;
            r_accum  <= '0;
            for (int i = 0; i < NUM_CENTERS; i++) begin
                r_w[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_ovalid <= n_ovalid;
            r_ih1    <= n_ih1;
            r_ih2    <= n_ih2;
            r_oh1    <= n_oh1;
            r_oh2    <= n_oh2;
            r_accum  <= n_accum;
            r_w      <= n_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass   <= MASS_RST;
            r_base   <= BASE_RST;
            r_gain   <= GAIN_RST;
            r_spread <= SPREAD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MASS:   r_mass   <= i_cfg_data;
                CFG_BASE:   r_base   <= i_cfg_data;
                CFG_GAIN:   r_gain   <= i_cfg_data;
                CFG_SPREAD: r_spread <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // working registers: no reset
    always_ff @(posedge i_clk) begin
        r_fe <= n_fe;  r_t <= n_t;  r_acc <= n_acc;  r_k <= n_k;
        r_w1 <= n_w1;  r_w3 <= n_w3;  r_num <= n_num;  r_b <= n_b;  r_y <= n_y;
        r_fault <= n_fault;  r_idx <= n_idx;  r_h <= n_h;  r_n <= n_n;
        r_r <= n_r;  r_p <= n_p;  r_kk <= n_kk;
        r_ma <= n_ma;  r_mb <= n_mb;  r_mneg <= n_mneg;  r_prod <= n_prod;
        r_mcnt <= n_mcnt;  r_qres <= n_qres;
        r_rem <= n_rem;  r_dsh <= n_dsh;  r_dd <= n_dd;  r_quo <= n_quo;
        r_dcnt <= n_dcnt;  r_dneg <= n_dneg;
        r_odata <= n_odata;
    end

    // a taken transaction drops ready until the result is built
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("ready still high after an input transaction");

    // a new result only appears out of the final state
    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state == S_FIN))
        else $error("result raised outside the final state");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    // a divisor fault always yields a clipped or zero correction
    a_fault_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.divide_fault) |->
        (o_out.data.offset_step == '0 ||
         o_out.data.offset_step == {1'b0, {(DATA_WIDTH-1){1'b1}}} ||
         o_out.data.offset_step == {1'b1, {(DATA_WIDTH-1){1'b0}}}))
        else $error("fault result not saturated");

endmodule
